FILE: rtl/tspc_pkg.sv
// Shared types, codes and constants for the torque sensor poll controller.
`timescale 1ns / 1ps

package tspc_pkg;

    localparam logic [1:0] CMD_STEP = 2'd0;
    localparam logic [1:0] CMD_RX   = 2'd1;
    localparam logic [1:0] CMD_ZERO = 2'd2;

    localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_POLL_PERIOD      = 2'd1;
    localparam logic [1:0] REG_OFFLINE          = 2'd2;
    localparam logic [1:0] REG_RATE_WINDOW      = 2'd3;

    localparam logic [7:0]  RESPONSE_TIMEOUT_RST = 8'd3;
    localparam logic [7:0]  POLL_PERIOD_RST      = 8'd2;
    localparam logic [15:0] OFFLINE_RST          = 16'd50;
    localparam logic [15:0] RATE_WINDOW_RST      = 16'd1000;

    localparam logic [28:0] REPLY_ID  = 29'h410;
    localparam logic [6:0]  FRAME_LEN = 7'd7;
    localparam logic [7:0]  FC_READ   = 8'h04;
    localparam logic [7:0]  FC_ZERO   = 8'h10;

    localparam logic [55:0] PAYLOAD_READ = 56'h04000000000000;
    localparam logic [55:0] PAYLOAD_ZERO = 56'h1046043F800000;

    localparam logic       KIND_READ = 1'b0;
    localparam logic       KIND_ZERO = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 144;

    typedef struct packed {
        logic [7:0]  response_timeout_ms;
        logic [7:0]  poll_period_ms;
        logic [15:0] offline_ms;
        logic [15:0] rate_window_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic        bus_accepts;
        logic        rx_extended;
        logic [28:0] rx_id;
        logic [6:0]  rx_len;
        logic [55:0] rx_data;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic        tx_kind;
        logic [55:0] tx_payload;
        logic        request_accepted;
        logic [31:0] torque_bits;
        logic [31:0] sample_seq;
        logic        zero_done;
        logic        online;
        logic [15:0] query_rate;
        logic        zero_timed_out;
    } result_t;

    typedef struct packed {
        logic        zero_mode;
        logic        in_flight;
        logic [31:0] send_time;
        logic        zero_pending;
        logic [15:0] sent_count;
        logic [31:0] window_start;
        logic        timeout_latch;
        logic        reply_seen;
        logic [31:0] last_poll_time;
        logic [31:0] last_reply_time;
        logic [31:0] torque;
        logic [31:0] seq_count;
        logic        zero_ok_flag;
        logic [15:0] rate;
    } state_t;

endpackage

FILE: rtl/tspc_cfg_regs.sv
// Configuration register file of the torque sensor poll controller.
`timescale 1ns / 1ps

module tspc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [tspc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tspc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tspc_pkg::cfg_t                   cfg
);

    tspc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.response_timeout_ms <= tspc_pkg::RESPONSE_TIMEOUT_RST;
            cfg_reg.poll_period_ms      <= tspc_pkg::POLL_PERIOD_RST;
            cfg_reg.offline_ms          <= tspc_pkg::OFFLINE_RST;
            cfg_reg.rate_window_ms      <= tspc_pkg::RATE_WINDOW_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tspc_pkg::REG_RESPONSE_TIMEOUT: cfg_reg.response_timeout_ms <= cfg_data[7:0];
                tspc_pkg::REG_POLL_PERIOD:      cfg_reg.poll_period_ms      <= cfg_data[7:0];
                tspc_pkg::REG_OFFLINE:          cfg_reg.offline_ms          <= cfg_data;
                tspc_pkg::REG_RATE_WINDOW:      cfg_reg.rate_window_ms      <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tspc_core.sv
// Poll and zero-calibration state with the per-word update and status logic.
`timescale 1ns / 1ps

module tspc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  tspc_pkg::item_t     item,
    input  tspc_pkg::cfg_t      cfg,
    output tspc_pkg::result_t   result
);

    tspc_pkg::state_t st_reg;
    tspc_pkg::state_t st_next;

    always_comb begin
        logic        send_ok;
        logic        valid_reply;
        logic [7:0]  fc;
        logic [31:0] now;
        logic [31:0] age;

        st_next = st_reg;
        now = item.now_ms;
        send_ok = 1'b0;
        valid_reply = 1'b0;
        fc = item.rx_data[55:48];
        result = '0;

        case (item.cmd)
            tspc_pkg::CMD_STEP: begin
                if ((now - st_reg.window_start) >= {16'd0, cfg.rate_window_ms}) begin
                    st_next.rate = st_reg.sent_count;
                    st_next.sent_count = '0;
                    st_next.window_start = now;
                end
                if (st_reg.zero_pending && !st_reg.in_flight) begin
                    st_next.zero_pending = 1'b0;
                    st_next.zero_mode = 1'b1;
                    send_ok = item.bus_accepts;
                    result.tx_kind = tspc_pkg::KIND_ZERO & item.bus_accepts;
                    result.tx_payload = item.bus_accepts ? tspc_pkg::PAYLOAD_ZERO : '0;
                end else if (!st_reg.zero_mode) begin
                    if (st_reg.in_flight) begin
                        if ((now - st_reg.send_time) >= {24'd0, cfg.response_timeout_ms}) begin
                            st_next.in_flight = 1'b0;
                        end
                    end else if ((now - st_reg.last_poll_time) >= {24'd0, cfg.poll_period_ms}) begin
                        st_next.last_poll_time = now;
                        send_ok = item.bus_accepts;
                        result.tx_kind = tspc_pkg::KIND_READ;
                        result.tx_payload = item.bus_accepts ? tspc_pkg::PAYLOAD_READ : '0;
                    end
                end else if (st_reg.in_flight &&
                             (now - st_reg.send_time) >= {24'd0, cfg.response_timeout_ms}) begin
                    st_next.in_flight = 1'b0;
                    st_next.zero_mode = 1'b0;
                    if (!st_reg.timeout_latch) begin
                        st_next.timeout_latch = 1'b1;
                        result.zero_timed_out = 1'b1;
                    end
                end
                // A frame the link took starts the response timer and counts toward the rate.
                if (send_ok) begin
                    st_next.in_flight = 1'b1;
                    st_next.send_time = now;
                    if (st_next.sent_count != 16'hFFFF) begin
                        st_next.sent_count = st_next.sent_count + 16'd1;
                    end
                end
            end
            tspc_pkg::CMD_RX: begin
                valid_reply = !item.rx_extended && (item.rx_id == tspc_pkg::REPLY_ID) &&
                              (item.rx_len >= tspc_pkg::FRAME_LEN);
                if (valid_reply) begin
                    st_next.last_reply_time = now;
                    st_next.in_flight = 1'b0;
                    st_next.reply_seen = 1'b1;
                    if (fc == tspc_pkg::FC_READ) begin
                        st_next.torque = item.rx_data[31:0];
                        st_next.seq_count = st_reg.seq_count + 32'd1;
                    end else if (fc == tspc_pkg::FC_ZERO) begin
                        st_next.zero_ok_flag = 1'b1;
                        st_next.timeout_latch = 1'b0;
                        st_next.zero_mode = 1'b0;
                    end
                end
            end
            tspc_pkg::CMD_ZERO: begin
                if (!st_reg.zero_pending && !st_reg.zero_mode) begin
                    st_next.zero_pending = 1'b1;
                    st_next.zero_ok_flag = 1'b0;
                    result.request_accepted = 1'b1;
                end
            end
            default: ;
        endcase

        age = now - st_next.last_reply_time;
        result.tx_valid = send_ok;
        result.torque_bits = st_next.torque;
        result.sample_seq = st_next.seq_count;
        result.zero_done = st_next.zero_ok_flag;
        result.online = st_next.reply_seen && (age < {16'd0, cfg.offline_ms});
        result.query_rate = st_next.rate;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: rtl/torque_sensor_poll_controller.sv
// Top level of the torque sensor poll controller: stream ports, word registers, config port.
`timescale 1ns / 1ps

// Each input word yields exactly one result word. A word accepted into the input register
// passes a single stage of compare and update logic against the poll state and loads its
// result into the output register once that register has room, from where it is offered on
// the result side. With the result side ready, one word is accepted in every cycle. While a
// result waits in the output register, the input register takes at most one more word, and
// the input side then stalls until the waiting result is taken. Configuration writes are
// accepted in every cycle; change registers only while no word is in progress.
module torque_sensor_poll_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms[31:0], bus_accepts, rx_extended, rx_id[28:0], rx_len[6:0], rx_data[55:0], zero pad
    input  logic [tspc_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tx_valid, tx_payload[55:0], request_accepted, torque_bits[31:0], sample_seq[31:0],
    // zero_done, online, query_rate[15:0], zero_timed_out, zero pad
    output logic [tspc_pkg::M_TDATA_W-1:0]    m_tdata,
    // tx_kind
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tspc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tspc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tspc_pkg::cfg_t    cfg;
    tspc_pkg::item_t   in_item_reg;
    tspc_pkg::result_t result;
    tspc_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              fire;

    assign cfg_ready = 1'b1;

    tspc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The registered word is processed once the result register has room.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.cmd         <= s_tuser;
            in_item_reg.now_ms      <= s_tdata[31:0];
            in_item_reg.bus_accepts <= s_tdata[32];
            in_item_reg.rx_extended <= s_tdata[33];
            in_item_reg.rx_id       <= s_tdata[62:34];
            in_item_reg.rx_len      <= s_tdata[69:63];
            in_item_reg.rx_data     <= s_tdata[125:70];
        end
    end

    tspc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.tx_kind;
    assign m_tdata  = {3'b000,
                       out_reg.zero_timed_out,
                       out_reg.query_rate,
                       out_reg.online,
                       out_reg.zero_done,
                       out_reg.sample_seq,
                       out_reg.torque_bits,
                       out_reg.request_accepted,
                       out_reg.tx_payload,
                       out_reg.tx_valid};

endmodule

FILE: rtl/tspc_checker.sv
// Port-level checks for the torque sensor poll controller, bound to the top level.
`timescale 1ns / 1ps

module tspc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tspc_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);

    // A held result word must not change while the sink stalls.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A zero frame kind is only reported together with a sent frame.
    a_kind_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[0])
        else $error("zero kind without a sent frame");

    // The sent payload matches its frame kind, and is empty when nothing was sent.
    a_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] && (m_tdata[56:1] == 56'd0)) ||
                     (m_tdata[0] && !m_tuser && m_tdata[56:1] == tspc_pkg::PAYLOAD_READ) ||
                     (m_tdata[0] && m_tuser && m_tdata[56:1] == tspc_pkg::PAYLOAD_ZERO))
        else $error("payload does not match frame kind");

    // An accepted zero request comes from a request word, never from a step word.
    a_req_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[57] |-> !m_tdata[0] && !m_tdata[140])
        else $error("request accepted together with step activity");

endmodule

bind torque_sensor_poll_controller tspc_checker u_tspc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/poll_status_checker.sv
// Checker that predicts and compares every result word of the torque sensor poll controller.
`timescale 1ns / 1ps

module poll_status_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tspc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tspc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tspc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              results_owed
);
    import tspc_pkg::*;

    cfg_t    regs;
    state_t  st;
    item_t   word;
    result_t got;
    result_t want;
    result_t status_due[$];
    int      mismatches = 0;

    assign fail_count = mismatches;

    initial results_owed = 0;

    // Hands a frame to the link; the link only takes it when it says it is ready.
    function automatic logic link_takes(input logic ready, input logic [31:0] t);
        if (!ready) begin
            return 1'b0;
        end
        st.in_flight = 1'b1;
        st.send_time = t;
        if (st.sent_count != 16'hFFFF) begin
            st.sent_count = st.sent_count + 16'd1;
        end
        return 1'b1;
    endfunction

    function automatic result_t next_status(input item_t w);
        result_t     r;
        logic [31:0] t;
        r = '0;
        t = w.now_ms;
        case (w.cmd)
            CMD_STEP: begin
                if (t - st.window_start >= 32'(regs.rate_window_ms)) begin
                    st.rate = st.sent_count;
                    st.sent_count = '0;
                    st.window_start = t;
                end
                if (st.zero_pending && !st.in_flight) begin
                    // The zero mode is entered even when the link refuses the frame.
                    st.zero_pending = 1'b0;
                    st.zero_mode = 1'b1;
                    if (link_takes(w.bus_accepts, t)) begin
                        r.tx_valid = 1'b1;
                        r.tx_kind = KIND_ZERO;
                        r.tx_payload = PAYLOAD_ZERO;
                    end
                end else if (!st.zero_mode) begin
                    if (st.in_flight) begin
                        if (t - st.send_time >= 32'(regs.response_timeout_ms)) begin
                            st.in_flight = 1'b0;
                        end
                    end else if (t - st.last_poll_time >= 32'(regs.poll_period_ms)) begin
                        st.last_poll_time = t;
                        if (link_takes(w.bus_accepts, t)) begin
                            r.tx_valid = 1'b1;
                            r.tx_kind = KIND_READ;
                            r.tx_payload = PAYLOAD_READ;
                        end
                    end
                end else if (st.in_flight &&
                             t - st.send_time >= 32'(regs.response_timeout_ms)) begin
                    st.in_flight = 1'b0;
                    st.zero_mode = 1'b0;
                    if (!st.timeout_latch) begin
                        st.timeout_latch = 1'b1;
                        r.zero_timed_out = 1'b1;
                    end
                end
            end
            CMD_RX: begin
                if (!w.rx_extended && w.rx_id == REPLY_ID && w.rx_len >= FRAME_LEN) begin
                    st.last_reply_time = t;
                    st.in_flight = 1'b0;
                    st.reply_seen = 1'b1;
                    case (w.rx_data[55:48])
                        FC_READ: begin
                            st.torque = w.rx_data[31:0];
                            st.seq_count = st.seq_count + 32'd1;
                        end
                        FC_ZERO: begin
                            st.zero_ok_flag = 1'b1;
                            st.timeout_latch = 1'b0;
                            st.zero_mode = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            CMD_ZERO: begin
                if (!st.zero_pending && !st.zero_mode) begin
                    st.zero_pending = 1'b1;
                    st.zero_ok_flag = 1'b0;
                    r.request_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.torque_bits = st.torque;
        r.sample_seq = st.seq_count;
        r.zero_done = st.zero_ok_flag;
        r.online = st.reply_seen && (t - st.last_reply_time < 32'(regs.offline_ms));
        r.query_rate = st.rate;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.response_timeout_ms = RESPONSE_TIMEOUT_RST;
            regs.poll_period_ms = POLL_PERIOD_RST;
            regs.offline_ms = OFFLINE_RST;
            regs.rate_window_ms = RATE_WINDOW_RST;
            st = '0;
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RESPONSE_TIMEOUT: regs.response_timeout_ms = cfg_data[7:0];
                    REG_POLL_PERIOD:      regs.poll_period_ms = cfg_data[7:0];
                    REG_OFFLINE:          regs.offline_ms = cfg_data;
                    REG_RATE_WINDOW:      regs.rate_window_ms = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.tx_valid = m_tdata[0];
                got.tx_kind = m_tuser;
                got.tx_payload = m_tdata[56:1];
                got.request_accepted = m_tdata[57];
                got.torque_bits = m_tdata[89:58];
                got.sample_seq = m_tdata[121:90];
                got.zero_done = m_tdata[122];
                got.online = m_tdata[123];
                got.query_rate = m_tdata[139:124];
                got.zero_timed_out = m_tdata[140];
                if (status_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word with nothing expected, got %h",
                             $time, m_tdata);
                end else begin
                    want = status_due.pop_front();
                    compare_field("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
                    compare_field("tx_kind", 64'(want.tx_kind), 64'(got.tx_kind));
                    compare_field("tx_payload", 64'(want.tx_payload), 64'(got.tx_payload));
                    compare_field("request_accepted", 64'(want.request_accepted),
                                  64'(got.request_accepted));
                    compare_field("torque_bits", 64'(want.torque_bits),
                                  64'(got.torque_bits));
                    compare_field("sample_seq", 64'(want.sample_seq), 64'(got.sample_seq));
                    compare_field("zero_done", 64'(want.zero_done), 64'(got.zero_done));
                    compare_field("online", 64'(want.online), 64'(got.online));
                    compare_field("query_rate", 64'(want.query_rate), 64'(got.query_rate));
                    compare_field("zero_timed_out", 64'(want.zero_timed_out),
                                  64'(got.zero_timed_out));
                end
            end
            if (s_tvalid && s_tready) begin
                word.cmd = s_tuser;
                word.now_ms = s_tdata[31:0];
                word.bus_accepts = s_tdata[32];
                word.rx_extended = s_tdata[33];
                word.rx_id = s_tdata[62:34];
                word.rx_len = s_tdata[69:63];
                word.rx_data = s_tdata[125:70];
                status_due.push_back(next_status(word));
            end
        end
        results_owed <= status_due.size();
    end

endmodule

FILE: tb/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the torque sensor poll controller.
`timescale 1ns / 1ps

module tb;
    import tspc_pkg::*;

    // The command field has one spare code; the block must treat it as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata = '0;
    logic [1:0]               s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     m_tuser;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    int                       fail_count;
    int                       results_owed;

    logic        full_speed = 1'b0;
    logic        sender_quiet = 1'b0;
    logic        ready_quiet = 1'b0;
    logic [31:0] ms_now = '0;

    always #2 aclk = ~aclk;

    torque_sensor_poll_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    poll_status_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] t, input logic acc,
                             input logic ext, input logic [28:0] id, input logic [6:0] len,
                             input logic [55:0] data);
        int gap;
        gap = (full_speed || sender_quiet) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, data, len, id, ext, acc, t};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Stops sending and waits until every result word has come back.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
    endtask

    task automatic configure(input logic [15:0] timeout_v, input logic [15:0] poll_v,
                             input logic [15:0] offline_v, input logic [15:0] window_v);
        put_reg(REG_RESPONSE_TIMEOUT, timeout_v);
        put_reg(REG_POLL_PERIOD, poll_v);
        put_reg(REG_OFFLINE, offline_v);
        put_reg(REG_RATE_WINDOW, window_v);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a well-behaved sensor conversation with a slowly advancing clock, mixed
    // with malformed frames, time jumps and spare commands.
    task automatic random_run(input int count);
        int          pick;
        logic [1:0]  cmd;
        logic        acc;
        logic        ext;
        logic [28:0] id;
        logic [6:0]  len;
        logic [55:0] data;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 63) == 0) begin
                sender_quiet = !sender_quiet;
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                ms_now += $urandom_range(0, 3);
            end else if (pick < 95) begin
                ms_now += $urandom_range(4, 40);
            end else if (pick < 99) begin
                ms_now += $urandom_range(41, 3000);
            end else begin
                ms_now = $urandom;
            end
            acc = ($urandom_range(0, 4) != 0);
            ext = 1'($urandom_range(0, 1));
            id = 29'($urandom);
            len = 7'($urandom);
            data = 56'({$urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                cmd = CMD_STEP;
            end else if (pick < 80) begin
                cmd = CMD_RX;
                ext = 1'b0;
                id = REPLY_ID;
                len = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(7, 127))
                                                  : 7'($urandom_range(7, 64));
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    data[55:48] = FC_READ;
                end else if (pick < 8) begin
                    data[55:48] = FC_ZERO;
                end
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 2))
                        0: ext = 1'b1;
                        1: id = REPLY_ID ^ (29'd1 << $urandom_range(0, 28));
                        default: len = 7'($urandom_range(0, 6));
                    endcase
                end
            end else if (pick < 92) begin
                cmd = CMD_ZERO;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_item(cmd, ms_now, acc, ext, id, len, data);
        end
    endtask

    initial begin
        int stall;
        forever begin
            if ($urandom_range(0, 63) == 0) begin
                ready_quiet = !ready_quiet;
            end
            stall = (full_speed || ready_quiet) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk through polling, reply filtering and the zero calibration cycle.
        send_item(CMD_UNUSED, 32'd5, 1'b1, 1'b1, '1, '1, '1);
        send_item(CMD_STEP, 32'd10, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_RX, 32'd11, 1'b0, 1'b0, REPLY_ID, FRAME_LEN,
                  {FC_READ, 16'hABCD, 32'h4120_0000});
        send_item(CMD_STEP, 32'd12, 1'b0, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd14, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd15, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd17, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_RX, 32'd18, 1'b0, 1'b1, REPLY_ID, FRAME_LEN, {FC_READ, 48'h1});
        send_item(CMD_RX, 32'd18, 1'b0, 1'b0, REPLY_ID + 29'd1, FRAME_LEN, {FC_READ, 48'h2});
        send_item(CMD_RX, 32'd18, 1'b0, 1'b0, REPLY_ID, FRAME_LEN - 7'd1, {FC_READ, 48'h3});
        send_item(CMD_RX, 32'd19, 1'b0, 1'b0, REPLY_ID, 7'd64, {8'h55, 48'h4});
        send_item(CMD_ZERO, 32'd20, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_ZERO, 32'd20, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd21, 1'b0, 1'b0, '0, '0, '0);
        send_item(CMD_ZERO, 32'd22, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd40, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_RX, 32'd41, 1'b0, 1'b0, REPLY_ID, FRAME_LEN, {FC_ZERO, 48'h0});
        send_item(CMD_ZERO, 32'd42, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd43, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd46, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_ZERO, 32'd47, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd48, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd51, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_STEP, 32'd1100, 1'b1, 1'b0, '0, '0, '0);
        send_item(CMD_RX, 32'hFFFF_FFFF, 1'b0, 1'b0, REPLY_ID, 7'd127,
                  {FC_READ, 48'hFFFF_FFFF_FFFF});
        send_item(CMD_STEP, 32'd1, 1'b1, 1'b1, '1, '1, '1);
        ms_now = 32'd1;

        wait_results();
        configure(16'd1, 16'd0, 16'd1, 16'd1);
        random_run(400);

        wait_results();
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_run(400);

        wait_results();
        configure(16'($urandom_range(1, 8)), 16'($urandom_range(0, 6)),
                  16'($urandom_range(1, 200)), 16'($urandom_range(1, 300)));
        random_run(500);

        // Any register value, including the ones outside the documented range.
        wait_results();
        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_run(400);

        // A burst of back-to-back steps at a frozen time: with a zero timeout and poll
        // period, every other step sends a query, and a last step far ahead rolls the window.
        wait_results();
        configure(16'd0, 16'd0, 16'd50, 16'd1);
        full_speed = 1'b1;
        ms_now += 32'd10;
        send_item(CMD_RX, ms_now, 1'b1, 1'b0, REPLY_ID, FRAME_LEN, {FC_ZERO, 48'h0});
        repeat (3) send_item(CMD_STEP, ms_now, 1'b1, 1'b0, '0, '0, '0);
        wait_results();
        configure(16'd0, 16'd0, 16'd50, 16'hFFFF);
        for (int i = 0; i < 40; i++) begin
            send_item(CMD_STEP, ms_now, 1'b1, 1'b0, '0, '0, '0);
        end
        send_item(CMD_STEP, ms_now + 32'h0000_FFFF, 1'b1, 1'b0, '0, '0, '0);
        full_speed = 1'b0;

        wait_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
